[design/mfh_pkg.sv]
`timescale 1ns / 1ps

package mfh_pkg;

  localparam int unsigned LenW   = 28;
  localparam int unsigned LimitW = 29;

  localparam logic [LimitW-1:0] LimitReset = 29'd65536;

  localparam logic [1:0] ROLE_HEADER  = 2'd0;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd1;
  localparam logic [1:0] ROLE_DROPPED = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_CLOSED    = 2'd3;

  localparam logic [7:0] MoreBit   = 8'h80;
  localparam logic [7:0] ValueMask = 8'h7f;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [1:0]      byte_role;
    logic [7:0]      packet_kind;
    logic [LenW-1:0] payload_length;
    logic            packet_end;
    logic [1:0]      status;
  } mfh_result_t;

endpackage

[design/mfh_in_if.sv]
`timescale 1ns / 1ps

interface mfh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[design/mfh_out_if.sv]
`timescale 1ns / 1ps

interface mfh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [1:0]  byte_role;
  logic [7:0]  packet_kind;
  logic [27:0] payload_length;
  logic        packet_end;
  logic [1:0]  status;

  modport source (
    output valid, output data_byte, output byte_role, output packet_kind,
    output payload_length, output packet_end, output status, input ready
  );
  modport sink (
    input valid, input data_byte, input byte_role, input packet_kind,
    input payload_length, input packet_end, input status, output ready
  );
endinterface

[design/mfh_core.sv]
`timescale 1ns / 1ps

module mfh_core
  import mfh_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [LimitW-1:0] wr_data,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output mfh_result_t       result
);

  localparam int unsigned SeenW = $clog2(MAX_LENGTH_BYTES + 1);

  localparam logic [1:0] PH_CMD = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  logic [LimitW-1:0] first_packet_limit;
  logic [1:0]        phase, phase_next;
  logic [7:0]        current_command, current_command_next;
  logic [SeenW-1:0]  length_bytes_seen, length_bytes_seen_next;
  logic [LenW-1:0]   length_accumulator, length_accumulator_next;
  logic [LenW-1:0]   payload_remaining, payload_remaining_next;
  logic              first_packet_done, first_packet_done_next;
  logic              error_latched, error_latched_next;

  logic [1:0]      seen_ext;
  logic [LenW-1:0] group_value, shifted, acc_sum, rem_dec;
  logic [SeenW-1:0] seen_inc;
  logic [LenW+1:0] total;

  always_comb begin
    seen_ext    = 2'(length_bytes_seen);
    group_value = LenW'(rx_byte & ValueMask);
    unique case (seen_ext)
      2'd0: shifted = group_value;
      2'd1: shifted = group_value << 7;
      2'd2: shifted = group_value << 14;
      2'd3: shifted = group_value << 21;
      default: shifted = group_value;
    endcase
    acc_sum  = length_accumulator + shifted;
    seen_inc = length_bytes_seen + SeenW'(1);
    total    = {2'b00, acc_sum} + (LenW+2)'(1) + (LenW+2)'(seen_inc);
    rem_dec  = payload_remaining - LenW'(1);
  end

  always_comb begin
    phase_next              = phase;
    current_command_next    = current_command;
    length_bytes_seen_next  = length_bytes_seen;
    length_accumulator_next = length_accumulator;
    payload_remaining_next  = payload_remaining;
    first_packet_done_next  = first_packet_done;
    error_latched_next      = error_latched;
    result.data_byte        = rx_byte;
    result.byte_role        = ROLE_HEADER;
    result.packet_kind      = current_command;
    result.payload_length   = length_accumulator;
    result.packet_end       = 1'b0;
    result.status           = ST_OK;

    if (error_latched) begin
      result.byte_role      = ROLE_DROPPED;
      result.packet_kind    = 8'd0;
      result.payload_length = '0;
      result.status         = ST_CLOSED;
    end else if (phase == PH_LEN) begin
      if (length_bytes_seen >= SeenW'(MAX_LENGTH_BYTES)) begin
        error_latched_next = 1'b1;
        result.byte_role   = ROLE_DROPPED;
        result.status      = ST_TOO_LONG;
      end else begin
        length_accumulator_next = acc_sum;
        length_bytes_seen_next  = seen_inc;
        result.payload_length   = acc_sum;
        if ((rx_byte & MoreBit) != 8'd0) begin
          result.byte_role = ROLE_HEADER;
        end else if (!first_packet_done && total >= (LenW+2)'(first_packet_limit)) begin
          error_latched_next = 1'b1;
          result.byte_role   = ROLE_DROPPED;
          result.status      = ST_TOO_LARGE;
        end else begin
          first_packet_done_next = 1'b1;
          if (acc_sum == '0) begin
            phase_next        = PH_CMD;
            result.packet_end = 1'b1;
          end else begin
            phase_next             = PH_PAY;
            payload_remaining_next = acc_sum;
          end
        end
      end
    end else if (phase == PH_PAY) begin
      payload_remaining_next = rem_dec;
      result.byte_role       = ROLE_PAYLOAD;
      if (rem_dec == '0) begin
        result.packet_end = 1'b1;
        phase_next        = PH_CMD;
      end
    end else begin
      current_command_next    = rx_byte;
      length_bytes_seen_next  = '0;
      length_accumulator_next = '0;
      payload_remaining_next  = '0;
      phase_next              = PH_LEN;
      result.packet_kind      = rx_byte;
      result.payload_length   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_packet_limit <= LimitReset;
      phase              <= PH_CMD;
      current_command    <= '0;
      length_bytes_seen  <= '0;
      length_accumulator <= '0;
      payload_remaining  <= '0;
      first_packet_done  <= 1'b0;
      error_latched      <= 1'b0;
    end else begin
      if (wr_en) begin
        first_packet_limit <= wr_data;
      end
      if (accept) begin
        phase              <= phase_next;
        current_command    <= current_command_next;
        length_bytes_seen  <= length_bytes_seen_next;
        length_accumulator <= length_accumulator_next;
        payload_remaining  <= payload_remaining_next;
        first_packet_done  <= first_packet_done_next;
        error_latched      <= error_latched_next;
      end
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("error flag cleared without reset");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (payload_remaining != '0))
    else $error("payload phase with nothing left to receive");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    length_bytes_seen <= SeenW'(MAX_LENGTH_BYTES))
    else $error("length byte count beyond the field limit");

endmodule

[design/mfh_out_reg.sv]
`timescale 1ns / 1ps

module mfh_out_reg
  import mfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mfh_result_t push_data,
  output logic        push_ready,
  mfh_out_if.source   res
);

  mfh_result_t main_data, skid_data;
  logic        main_valid, skid_valid;
  logic        pop;

  assign pop        = main_valid && res.ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

  assign res.valid          = main_valid;
  assign res.data_byte      = main_data.data_byte;
  assign res.byte_role      = main_data.byte_role;
  assign res.packet_kind    = main_data.packet_kind;
  assign res.payload_length = main_data.payload_length;
  assign res.packet_end     = main_data.packet_end;
  assign res.status         = main_data.status;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("second entry held while the first is empty");

endmodule

[design/mqtt_fixed_header_deframer.sv]
`timescale 1ns / 1ps

// Splits a received byte stream into packets, one byte per clock while rx is
// ready. Each accepted byte appears on res, tagged as header, payload or
// dropped, with the command byte of its packet, the decoded remaining length
// and an end-of-packet mark. A two-entry output stage lets rx keep accepting
// a byte every cycle while one result waits; rx ready falls only when both
// entries are held by a stalled sink. Errors are sticky until reset. The
// user writes the first packet limit via wr_en and wr_data while the block
// is idle; this is not enforced. There is no memory and no start-up sweep.
module mqtt_fixed_header_deframer
  import mfh_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [LimitW-1:0] wr_data,
  mfh_in_if.sink            rx,
  mfh_out_if.source         res
);

  mfh_result_t result;
  logic        accept;
  logic        push_ready;

  assign rx.ready = push_ready;
  assign accept   = rx.valid && push_ready;

  mfh_core #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .result  (result)
  );

  mfh_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .res        (res)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mfh_pkg::*;

  localparam int unsigned MaxLenBytes = 4;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned TargetBytes = 1950;
  localparam int unsigned CalmTail    = 120;

  typedef enum logic [1:0] {PH_AWAIT_CMD, PH_LENGTH, PH_PAYLOAD} deframe_phase_e;

  typedef struct {
    bit          is_cfg;
    logic [28:0] value;
  } rx_plan_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en = 1'b0;
  logic [LimitW-1:0] wr_data = '0;

  mfh_in_if  rx ();
  mfh_out_if res ();

  mqtt_fixed_header_deframer #(
    .MAX_LENGTH_BYTES(MaxLenBytes)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rx      (rx),
    .res     (res)
  );

  rx_plan_t    rx_plan[$];
  mfh_result_t pending_tags[$];
  int unsigned planned_bytes = 0;

  // Shadow of the deframer state, advanced once per accepted item.
  deframe_phase_e    shadow_phase = PH_AWAIT_CMD;
  logic [7:0]        shadow_cmd = '0;
  int unsigned       shadow_seen = 0;
  logic [LenW-1:0]   shadow_acc = '0;
  logic [LenW-1:0]   shadow_left = '0;
  bit                shadow_first_done = 1'b0;
  bit                shadow_closed = 1'b0;
  logic [LimitW-1:0] limit_model = LimitReset;

  bit          rx_fired = 1'b0;
  int unsigned cycles = 0;
  int unsigned n_bytes_in = 0;
  int unsigned n_checked = 0;
  int unsigned n_bad = 0;
  int unsigned n_packets = 0;
  int unsigned n_limit_writes = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  int unsigned tx_gap = 0;
  int unsigned tx_idle_pct = 6;
  int unsigned rx_stall = 0;
  int unsigned sink_idle_pct = 6;
  int unsigned hold_left = 0;
  int unsigned hold_at = 300;
  bit          hold_armed = 1'b1;
  bit          reject_run = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic mfh_result_t deframe_byte(logic [7:0] b);
    mfh_result_t r;
    logic [30:0] total;
    r.data_byte      = b;
    r.byte_role      = ROLE_HEADER;
    r.packet_kind    = shadow_cmd;
    r.payload_length = shadow_acc;
    r.packet_end     = 1'b0;
    r.status         = ST_OK;
    if (shadow_closed) begin
      r.byte_role      = ROLE_DROPPED;
      r.packet_kind    = '0;
      r.payload_length = '0;
      r.status         = ST_CLOSED;
      return r;
    end
    case (shadow_phase)
      PH_LENGTH: begin
        if (shadow_seen >= MaxLenBytes) begin
          shadow_closed = 1'b1;
          r.byte_role   = ROLE_DROPPED;
          r.status      = ST_TOO_LONG;
        end else begin
          shadow_acc = shadow_acc + (LenW'(b & ValueMask) << (7 * shadow_seen));
          shadow_seen++;
          r.payload_length = shadow_acc;
          if ((b & MoreBit) == 8'h00) begin
            total = 31'(shadow_acc) + 31'(shadow_seen) + 31'd1;
            if (!shadow_first_done && total >= 31'(limit_model)) begin
              shadow_closed = 1'b1;
              r.byte_role   = ROLE_DROPPED;
              r.status      = ST_TOO_LARGE;
            end else begin
              shadow_first_done = 1'b1;
              if (shadow_acc == '0) begin
                shadow_phase = PH_AWAIT_CMD;
                r.packet_end = 1'b1;
              end else begin
                shadow_phase = PH_PAYLOAD;
                shadow_left  = shadow_acc;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        shadow_left = shadow_left - 1'b1;
        r.byte_role = ROLE_PAYLOAD;
        if (shadow_left == '0) begin
          shadow_phase = PH_AWAIT_CMD;
          r.packet_end = 1'b1;
        end
      end
      default: begin
        shadow_cmd       = b;
        shadow_seen      = 0;
        shadow_acc       = '0;
        shadow_left      = '0;
        shadow_phase     = PH_LENGTH;
        r.packet_kind    = b;
        r.payload_length = '0;
      end
    endcase
    return r;
  endfunction

  function automatic void plan_byte(logic [7:0] b);
    rx_plan.push_back('{1'b0, 29'(b)});
    planned_bytes++;
  endfunction

  function automatic void plan_limit(logic [LimitW-1:0] v);
    rx_plan.push_back('{1'b1, v});
  endfunction

  // Command byte and a length field of nlen bytes; zero groups pad a short value.
  function automatic void plan_header(logic [7:0] cmd, int unsigned len, int unsigned nlen);
    logic [7:0] g;
    plan_byte(cmd);
    for (int unsigned i = 0; i < nlen; i++) begin
      g = 8'((len >> (7 * i)) & 32'h7f);
      if (i + 1 < nlen) g = g | MoreBit;
      plan_byte(g);
    end
  endfunction

  function automatic int unsigned min_len_bytes(int unsigned len);
    if (len < 128) return 1;
    if (len < 16384) return 2;
    if (len < 2097152) return 3;
    return 4;
  endfunction

  function automatic void plan_packet(logic [7:0] cmd, int unsigned len, int unsigned extra);
    int unsigned nlen;
    nlen = min_len_bytes(len) + extra;
    if (nlen > MaxLenBytes) nlen = MaxLenBytes;
    plan_header(cmd, len, nlen);
    repeat (len) plan_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic bit calm_tail();
    return rx_plan.size() < CalmTail;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 6;
      default: return 30;
    endcase
  endfunction

  always @(posedge clk) begin
    mfh_result_t got;
    mfh_result_t want;
    cycles++;
    rx_fired = !rst && rx.valid && rx.ready;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got.data_byte      = res.data_byte;
        got.byte_role      = res.byte_role;
        got.packet_kind    = res.packet_kind;
        got.payload_length = res.payload_length;
        got.packet_end     = res.packet_end;
        got.status         = res.status;
        if (pending_tags.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result: byte=%02h role=%0d kind=%02h len=%0d end=%0d st=%0d",
                     got.data_byte, got.byte_role, got.packet_kind, got.payload_length,
                     got.packet_end, got.status);
        end else begin
          want = pending_tags.pop_front();
          n_checked++;
          if (got.status inside {[0:3]}) status_seen[got.status]++;
          if (got.packet_end === 1'b1 && got.status === ST_OK) n_packets++;
          if (got.data_byte !== want.data_byte || got.byte_role !== want.byte_role ||
              got.packet_kind !== want.packet_kind ||
              got.payload_length !== want.payload_length ||
              got.packet_end !== want.packet_end || got.status !== want.status) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("mismatch on result %0d:", n_checked);
              $display("  expected byte=%02h role=%0d kind=%02h len=%0d end=%0d st=%0d",
                       want.data_byte, want.byte_role, want.packet_kind,
                       want.payload_length, want.packet_end, want.status);
              $display("  actual   byte=%02h role=%0d kind=%02h len=%0d end=%0d st=%0d",
                       got.data_byte, got.byte_role, got.packet_kind,
                       got.payload_length, got.packet_end, got.status);
            end
          end
        end
      end
      if (rx_fired) begin
        pending_tags.push_back(deframe_byte(rx.rx_byte));
        n_bytes_in++;
      end
      if (wr_en) begin
        limit_model = wr_data;
        n_limit_writes++;
      end
    end
  end

  // The limit is only written once every expected item has come back.
  always @(negedge clk) begin
    logic              nv;
    logic [7:0]        nb;
    logic              nw;
    logic [LimitW-1:0] nd;
    nv = rx.valid;
    nb = rx.rx_byte;
    nw = 1'b0;
    nd = wr_data;
    if ($urandom_range(0, 63) == 0) tx_idle_pct = pick_idle_pct();
    if (rst) begin
      nv = 1'b0;
    end else if (!(rx.valid && !rx_fired)) begin
      nv = 1'b0;
      if (wr_en) begin
        void'(rx_plan.pop_front());
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (rx_plan.size() > 0) begin
        if (rx_plan[0].is_cfg) begin
          if (pending_tags.size() == 0) begin
            nw = 1'b1;
            nd = rx_plan[0].value;
          end
        end else if (!calm_tail() && $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap = $urandom_range(1, 13) - 1;
        end else begin
          nv = 1'b1;
          nb = rx_plan[0].value[7:0];
          void'(rx_plan.pop_front());
        end
      end
    end
    rx.valid   <= nv;
    rx.rx_byte <= nb;
    wr_en      <= nw;
    wr_data    <= nd;
  end

  always @(negedge clk) begin
    logic nr;
    if ($urandom_range(0, 63) == 0) sink_idle_pct = pick_idle_pct();
    if (rst) begin
      nr = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (hold_armed && n_bytes_in >= hold_at) begin
      hold_armed = 1'b0;
      hold_left  = $urandom_range(60, 120);
      nr = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      nr = 1'b0;
    end else if (!calm_tail() && $urandom_range(0, 99) < sink_idle_pct) begin
      rx_stall = $urandom_range(1, 13) - 1;
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    res.ready <= nr;
  end

  initial begin
    int unsigned p;
    int unsigned nlen;
    int unsigned len;
    int unsigned extra;
    int unsigned next_write;
    bit          timed_out;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    res.ready  = 1'b0;

    // Errors are sticky, so a rejected first packet ends the useful part of a
    // run; one seed in five is spent on that case instead.
    reject_run = ($urandom_range(0, 4) == 0);
    if (reject_run) begin
      hold_at = 60;
      p    = $urandom_range(0, 40);
      nlen = $urandom_range(1, MaxLenBytes);
      case ($urandom_range(0, 3))
        0: plan_limit('0);
        1: plan_limit(29'd1);
        2: plan_limit(LimitW'(p + nlen + 1));
        default: begin
          plan_limit(LimitReset);
          p    = 65532;
          nlen = 3;
        end
      endcase
      plan_header(8'($urandom_range(0, 255)), p, nlen);
      while (planned_bytes < TargetBytes) plan_byte(8'($urandom_range(0, 255)));
    end else begin
      // The first packet sits one below the limit and must pass.
      p = $urandom_range(0, 6);
      plan_limit(LimitW'(p + 3));
      plan_packet(8'($urandom_range(0, 255)), p, 0);
      plan_packet(8'he0, 0, 0);
      plan_packet(8'h00, 0, 3);
      plan_packet(8'hff, 1, 1);
      plan_packet(8'h30, 2, 0);
      plan_limit('0);
      plan_limit({LimitW{1'b1}});
      next_write = planned_bytes + 400;
      while (planned_bytes < TargetBytes) begin
        if (planned_bytes >= next_write) begin
          case ($urandom_range(0, 3))
            0: plan_limit('0);
            1: plan_limit(29'd1);
            2: plan_limit({LimitW{1'b1}});
            default: plan_limit(LimitW'($urandom()));
          endcase
          next_write = planned_bytes + 400;
        end
        case ($urandom_range(0, 99)) inside
          [0:59]:  len = $urandom_range(0, 15);
          [60:84]: len = $urandom_range(16, 127);
          [85:96]: len = $urandom_range(128, 300);
          default: len = $urandom_range(0, 3);
        endcase
        extra = 0;
        if ($urandom_range(0, 3) == 0)
          extra = $urandom_range(0, MaxLenBytes - min_len_bytes(len));
        plan_packet(8'($urandom_range(0, 255)), len, extra);
      end
      // A length field that never ends closes the stream for good.
      plan_byte(8'($urandom_range(0, 255)));
      repeat (MaxLenBytes) plan_byte(8'hff);
      plan_byte(8'($urandom_range(0, 255)));
      repeat (30) plan_byte(8'($urandom_range(0, 255)));
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while ((rx_plan.size() > 0 || rx.valid || wr_en || pending_tags.size() > 0) &&
           cycles < CycleLimit)
      @(posedge clk);
    timed_out = (cycles >= CycleLimit);
    if (timed_out) begin
      $display("timed out after %0d cycles with %0d items still to send",
               cycles, rx_plan.size());
    end else begin
      repeat (DrainCycles) @(posedge clk);
    end
    if (pending_tags.size() > 0) begin
      n_bad++;
      $display("%0d expected results never arrived", pending_tags.size());
    end

    $display("Checked %0d bytes over %0d cycles: %0d packets closed cleanly, %0d limit writes.",
             n_checked, cycles, n_packets, n_limit_writes);
    $display("Statuses seen ok/too long/too large/closed: %0d/%0d/%0d/%0d; %0d mismatches.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], n_bad);
    if (!timed_out && n_bad == 0) begin
      $display("** mqtt_fixed_header_deframer: PASSED **");
    end else begin
      $display("** mqtt_fixed_header_deframer: FAILED **");
    end
    $finish;
  end

endmodule
